// ----- rtl/decimal_token_to_fixed_point_core_defines.svh -----
// assertion macros for the decimal token to fixed point core
// used by the top level only; every macro expects clk_i and rst_ni in scope
`ifndef DECIMAL_TOKEN_TO_FIXED_POINT_CORE_DEFINES_SVH
`define DECIMAL_TOKEN_TO_FIXED_POINT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define DTFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define DTFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DTFP_ASSERT(label, prop, msg)
`define DTFP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/dtfp_pkg.sv -----
// types, constants and the fraction weight table of the decimal token converter
// no dependencies
`timescale 1ns / 1ps

package dtfp_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned CountW   = 6;
  localparam int unsigned IntW     = 15;
  localparam int unsigned FracW    = 32;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned WIdxW    = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CharW-1:0]  CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0]  CHAR_POINT = 8'h2E;
  localparam logic [CharW-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0]  CHAR_NINE  = 8'h39;

  localparam logic [CountW-1:0] MAX_LEN_RESET = 6'd19;
  localparam logic [CountW-1:0] COUNT_MAX     = 6'd63;
  localparam logic [IntW-1:0]   INT_MAX       = 15'd32767;
  localparam logic [WIdxW-1:0]  WIDX_LAST     = 4'd9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SEPARATOR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LEN   = 2'd1;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_INT   = 3'b010,
    PH_FRAC  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              bad_char;
    logic              overflow;
    logic              truncated;
  } result_t;

  // Q0.32 weight of the n-th fraction digit: one tenth, divided by ten truncating
  function automatic logic [FracW-1:0] frac_weight(input logic [WIdxW-1:0] idx);
    logic [FracW-1:0] w;
    unique case (idx)
      4'd0:    w = 32'd429496729;
      4'd1:    w = 32'd42949672;
      4'd2:    w = 32'd4294967;
      4'd3:    w = 32'd429496;
      4'd4:    w = 32'd42949;
      4'd5:    w = 32'd4294;
      4'd6:    w = 32'd429;
      4'd7:    w = 32'd42;
      4'd8:    w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/decimal_token_to_fixed_point_core.sv -----
// Streaming decimal token parser: one ASCII character per item, signed Q15.16 out.
// Input channel valid/stall, result channel valid/stall, configuration write port.
// A character that ends a token (NUL or the separator) produces one result item;
// every other character only updates the token state and produces nothing.
// Optional leading minus, integer digits saturating at 32767, a point, then fraction
// digits weighted by a truncated tenth per place; the fraction is cut to 16 bits.
// Throughput: one character per cycle while in_stall_o is low. All token work
// happens in the cycle the character is taken; a terminating character's result
// goes to the output register, or to the skid slot while that register is stalled.
// The output register is backed by a one-entry skid buffer. When the receiver
// stalls, characters keep flowing until a second result has to be parked; then
// in_stall_o rises, from a register, until the receiver takes the waiting result.
// The user must write configuration (register 0 separator, register 1 length limit)
// with cfg_valid_i while the block is idle, unenforced; cfg_ready_o is always high.
// Reset clears the token state and both output slots and sets separator to space
// and the length limit to 19.
`timescale 1ns / 1ps
`include "decimal_token_to_fixed_point_core_defines.svh"

module decimal_token_to_fixed_point_core
  import dtfp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CharW-1:0]         character_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_o,
  output logic                     bad_char_o,
  output logic                     overflow_o,
  output logic                     truncated_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CharW-1:0]         cfg_data_i
);

  logic [CharW-1:0]  sep_q;
  logic [CountW-1:0] max_len_q;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [IntW-1:0]   int_q, int_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [WIdxW-1:0]  widx_q, widx_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              bad_q, bad_d;
  logic              ovf_q, ovf_d;
  logic              trunc_q, trunc_d;

  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              skid_valid_q, skid_valid_d;
  result_t           skid_q, skid_d;

  logic              in_acc;
  logic              is_term;
  logic              is_digit;
  logic [3:0]        digit;
  logic              take;
  logic              new_res;
  result_t           res;
  logic [ValueW-1:0] mag;
  logic [IntW+3:0]   int_sum;
  logic [FracW+4:0]  frac_sum;
  logic              out_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;

  assign is_term    = (character_i == CHAR_NUL) || (character_i == sep_q);
  assign is_digit   = (character_i >= CHAR_ZERO) && (character_i <= CHAR_NINE);
  // low nibble of an ascii digit is its value
  assign digit      = character_i[3:0];
  assign take       = in_acc && !is_term && (cnt_q < max_len_q);
  assign new_res    = in_acc && is_term;

  // integer times ten plus digit, as shifts
  assign int_sum  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + {15'b0, digit};
  assign frac_sum = {5'b0, frac_q} + ({33'b0, digit} * {5'b0, frac_weight(widx_q)});

  assign mag = {1'b0, int_q, frac_q[FracW-1 -: 16]};

  always_comb begin
    res.value     = neg_q ? (32'd0 - mag) : mag;
    res.bad_char  = bad_q;
    res.overflow  = ovf_q;
    res.truncated = trunc_q;
  end

  // token state
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    widx_d  = widx_q;
    cnt_d   = cnt_q;
    bad_d   = bad_q;
    ovf_d   = ovf_q;
    trunc_d = trunc_q;
    if (new_res) begin
      phase_d = PH_START;
      neg_d   = 1'b0;
      int_d   = '0;
      frac_d  = '0;
      widx_d  = '0;
      cnt_d   = '0;
      bad_d   = 1'b0;
      ovf_d   = 1'b0;
      trunc_d = 1'b0;
    end else if (in_acc && !take) begin
      trunc_d = 1'b1;
    end else if (take) begin
      if (cnt_q != COUNT_MAX) begin
        cnt_d = cnt_q + 6'd1;
      end
      if (character_i == CHAR_MINUS) begin
        // minus counts only as the first sign
        if (phase_q == PH_START) begin
          neg_d   = 1'b1;
          phase_d = PH_INT;
        end
      end else if (character_i == CHAR_POINT) begin
        phase_d = PH_FRAC;
      end else if (is_digit) begin
        if (phase_q == PH_FRAC) begin
          frac_d = (frac_sum > {5'b0, 32'hFFFF_FFFF}) ? 32'hFFFF_FFFF : frac_sum[FracW-1:0];
          if (widx_q != WIDX_LAST) begin
            widx_d = widx_q + 4'd1;
          end
        end else begin
          if (int_sum > {4'b0, INT_MAX}) begin
            int_d = INT_MAX;
            ovf_d = 1'b1;
          end else begin
            int_d = int_sum[IntW-1:0];
          end
          phase_d = PH_INT;
        end
      end else begin
        bad_d = 1'b1;
        if (phase_q == PH_START) begin
          phase_d = PH_INT;
        end
      end
    end
  end

  // output register with skid slot
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_take || !out_valid_q) begin
      out_valid_d  = skid_valid_q || new_res;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (new_res) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q        <= CHAR_SPACE;
      max_len_q    <= MAX_LEN_RESET;
      phase_q      <= PH_START;
      neg_q        <= 1'b0;
      int_q        <= '0;
      frac_q       <= '0;
      widx_q       <= '0;
      cnt_q        <= '0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
      trunc_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_SEPARATOR: sep_q     <= cfg_data_i;
          REG_MAX_LEN:   max_len_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      int_q        <= int_d;
      frac_q       <= frac_d;
      widx_q       <= widx_d;
      cnt_q        <= cnt_d;
      bad_q        <= bad_d;
      ovf_q        <= ovf_d;
      trunc_q      <= trunc_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(out_q.value);
  assign bad_char_o  = out_q.bad_char;
  assign overflow_o  = out_q.overflow;
  assign truncated_o = out_q.truncated;

  // a parked result always has one in front of it
  `DTFP_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with output empty")
  // weight index never runs past the zero weight
  `DTFP_ASSERT(a_widx_range, widx_q <= WIDX_LAST, "fraction weight index out of range")
  // a terminator always leaves a fresh token behind
  `DTFP_ASSERT_NEXT(a_term_clears, new_res, (cnt_q == '0) && (phase_q == PH_START), "not cleared")

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for decimal_token_to_fixed_point_core: character stream in, Q15.16 out
// depends on dtfp_pkg and the core RTL; a tracker class predicts and checks every result item
`timescale 1ns / 1ps

import dtfp_pkg::*;

class token_value_tracker;
  logic [CharW-1:0]  sep;
  logic [CountW-1:0] max_len;

  phase_e            phase;
  logic              negative;
  logic [IntW-1:0]   int_part;
  logic [FracW-1:0]  frac_sum;
  logic [FracW-1:0]  frac_weight;
  logic [CountW-1:0] char_count;
  logic              saw_bad;
  logic              saw_ovf;
  logic              saw_trunc;

  result_t           pending_values[$];
  int                errors;
  int                tokens_matched;

  function new();
    sep            = CHAR_SPACE;
    max_len        = MAX_LEN_RESET;
    errors         = 0;
    tokens_matched = 0;
    clear_token();
  endfunction

  function void clear_token();
    phase       = PH_START;
    negative    = 1'b0;
    int_part    = '0;
    frac_sum    = '0;
    frac_weight = 32'd429496729;
    char_count  = '0;
    saw_bad     = 1'b0;
    saw_ovf     = 1'b0;
    saw_trunc   = 1'b0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CharW-1:0] data);
    if (idx == REG_SEPARATOR) begin
      sep = data;
    end else if (idx == REG_MAX_LEN) begin
      max_len = data[CountW-1:0];
    end
  endfunction

  function void report_mismatch(string what);
    if (errors < 100) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    errors++;
  endfunction

  function void take_char(logic [CharW-1:0] c);
    logic [31:0] mag;
    logic [63:0] sum;
    logic [31:0] next_int;
    logic [31:0] digit;
    result_t     res;
    // a terminator ends the token even past the length limit
    if (c == CHAR_NUL || c == sep) begin
      mag           = {1'b0, int_part, frac_sum[31:16]};
      res.value     = negative ? (32'd0 - mag) : mag;
      res.bad_char  = saw_bad;
      res.overflow  = saw_ovf;
      res.truncated = saw_trunc;
      pending_values.push_back(res);
      clear_token();
      return;
    end
    if (char_count >= max_len) begin
      saw_trunc = 1'b1;
      return;
    end
    if (char_count < COUNT_MAX) begin
      char_count++;
    end
    if (c == CHAR_MINUS) begin
      if (phase == PH_START) begin
        negative = 1'b1;
        phase    = PH_INT;
      end
    end else if (c == CHAR_POINT) begin
      phase = PH_FRAC;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      digit = 32'(c - CHAR_ZERO);
      if (phase == PH_FRAC) begin
        sum         = 64'(frac_sum) + 64'(digit) * 64'(frac_weight);
        frac_sum    = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        frac_weight = frac_weight / 10;
      end else begin
        next_int = 32'(int_part) * 10 + digit;
        if (next_int > 32'(INT_MAX)) begin
          next_int = 32'(INT_MAX);
          saw_ovf  = 1'b1;
        end
        int_part = next_int[IntW-1:0];
        phase    = PH_INT;
      end
    end else begin
      saw_bad = 1'b1;
      if (phase == PH_START) begin
        phase = PH_INT;
      end
    end
  endfunction

  function void match_value(result_t got);
    result_t want;
    if (pending_values.size() == 0) begin
      report_mismatch($sformatf("result %0d with no token pending", $signed(got.value)));
      return;
    end
    want = pending_values.pop_front();
    if (got.value !== want.value) begin
      report_mismatch($sformatf("value got %0d want %0d",
                                $signed(got.value), $signed(want.value)));
    end
    if (got.bad_char !== want.bad_char) begin
      report_mismatch($sformatf("bad_char got %b want %b", got.bad_char, want.bad_char));
    end
    if (got.overflow !== want.overflow) begin
      report_mismatch($sformatf("overflow got %b want %b", got.overflow, want.overflow));
    end
    if (got.truncated !== want.truncated) begin
      report_mismatch($sformatf("truncated got %b want %b", got.truncated, want.truncated));
    end
    tokens_matched++;
  endfunction
endclass

module testbench;
  localparam int QuietLimit = 5000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [CharW-1:0]         character_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ValueW-1:0] value_o;
  logic                     bad_char_o;
  logic                     overflow_o;
  logic                     truncated_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = REG_SEPARATOR;
  logic [CharW-1:0]         cfg_data_i  = '0;

  token_value_tracker tracker = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int chars_sent    = 0;
  int quiet_cycles  = 0;

  decimal_token_to_fixed_point_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .bad_char_o  (bad_char_o),
    .overflow_o  (overflow_o),
    .truncated_o (truncated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // monitor both channels and watch for a hung block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.take_char(character_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.match_value('{value: value_o, bad_char: bad_char_o,
                              overflow: overflow_o, truncated: truncated_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    foreach (s[i]) begin
      send_char(s[i]);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CharW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    tracker.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // mostly well-formed numbers, some with stray characters, some pure noise
  task automatic send_token();
    logic [CharW-1:0] chars[$];
    int n_int;
    int n_frac;
    n_int  = 0;
    n_frac = 0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 25)) chars.push_back(CharW'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) begin
        chars.push_back(CHAR_MINUS);
      end
      n_int = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
      repeat (n_int) chars.push_back(CHAR_ZERO + CharW'($urandom_range(9)));
      if ($urandom_range(2) != 0) begin
        chars.push_back(CHAR_POINT);
        n_frac = $urandom_range(0, 12);
        repeat (n_frac) chars.push_back(CHAR_ZERO + CharW'($urandom_range(9)));
      end
      if ($urandom_range(9) == 0) begin
        chars.insert($urandom_range(chars.size()), CharW'($urandom_range(1, 255)));
      end
      if ($urandom_range(19) == 0) begin
        chars.insert($urandom_range(chars.size()),
                     $urandom_range(1) ? CHAR_MINUS : CHAR_POINT);
      end
    end
    chars.push_back($urandom_range(1) ? tracker.sep : CHAR_NUL);
    foreach (chars[i]) begin
      send_char(chars[i]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_values.size() != 0) begin
      @(posedge clk_i);
    end
    // result path is one register plus a skid slot
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [CharW-1:0]  sep_choice[6];
    logic [CountW-1:0] len_choice[6];
    int                phase_start;

    sep_choice = '{CHAR_SPACE, CHAR_NUL, 8'hFF, 8'h2C, CHAR_ZERO + 8'd5,
                   CharW'($urandom_range(255))};
    len_choice = '{MAX_LEN_RESET, COUNT_MAX, 6'd1, 6'd8, 6'd12,
                   CountW'($urandom_range(1, 63))};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(REG_SEPARATOR, sep_choice[ph]);
        write_reg(REG_MAX_LEN, {2'b00, len_choice[ph]});
      end
      case (ph / 2)
        0: begin
          in_idle_pct   = 23;
          out_stall_pct = 77;
        end
        1: begin
          in_idle_pct   = 77;
          out_stall_pct = 23;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      phase_start = chars_sent;
      if (ph == 0) begin
        // saturating negative number, then stray minus, second point, high byte, NUL
        send_string("-40000.5 ");
        send_string("7-.2.5");
        send_char(8'hFF);
        send_char(CHAR_NUL);
        send_char(CHAR_SPACE);
        send_string("32767 ");
      end
      while (chars_sent - phase_start < 250) begin
        send_token();
      end
      drain();
    end

    if (tracker.pending_values.size() != 0) begin
      tracker.report_mismatch($sformatf("%0d results never arrived",
                                        tracker.pending_values.size()));
    end
    $display("sent %0d characters, checked %0d token results across 6 register settings",
             chars_sent, tracker.tokens_matched);
    $display("idle mix: sender-heavy, receiver-heavy, then back to back; %0d mismatches",
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/dtfp_pkg.sv
rtl/decimal_token_to_fixed_point_core.sv
dv/testbench.sv
